>>> rtl/core/bvri_pkg.sv
// Package with shared codes, constants and the popcount function of the rank/position index.
`timescale 1ns / 1ps
`default_nettype none
package bvri_pkg;
	localparam int BV_SHIFT = 6;
	localparam logic [5:0] BV_BIT_MASK = 6'd63;

	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_START_OUT = 3'd1;
	localparam logic [2:0] ST_END_OUT   = 3'd2;
	localparam logic [2:0] ST_CROSS     = 3'd3;
	localparam logic [2:0] ST_ZERO_LEN  = 3'd4;
	localparam logic [2:0] ST_OVERFLOW  = 3'd5;
	localparam logic [2:0] ST_BAD_INDEX = 3'd6;

	localparam logic [0:0] REG_SEGMENT_COUNT = 1'd0;
	localparam logic [0:0] REG_CIRCULAR_MODE = 1'd1;

	function automatic logic [6:0] pop64(input logic [63:0] x);
		logic [6:0] n;
		n = '0;
		for (int k = 0; k < 64; k++) begin
			n = n + 7'(x[k]);
		end
		return n;
	endfunction
endpackage
`default_nettype wire

>>> rtl/core/bvri_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module bvri_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/bitvector_rank_position_index_core.sv
// Top level of the position-to-segment rank/select index.
// After reset every entry of the length store is cleared with the input held not ready.
// A load goes straight to the done state; a query does so on an error or a whole-span request,
// and when both positions are located it first reads the shared rank and bitvector memories at the
// start word and then at the end word. A build walks the length store once to sum the lengths,
// checks the sum against the capacity, then sweeps all BIT_WORDS words of the bitvector, reading
// the length of every segment that starts before the total length.
// Results leave through an output register, so one result may wait while the next transaction runs.
`timescale 1ns / 1ps
`default_nettype none
module bitvector_rank_position_index_core
	import bvri_pkg::*;
#(
	parameter int MAX_SEGMENTS = 1024,
	parameter int BIT_WORDS = 4096
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [10:0]        cfg_wdata,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         op,
	input  wire logic [9:0]         segment_index,
	input  wire logic [15:0]        segment_length,
	input  wire logic               whole_span,
	input  wire logic signed [18:0] start_coord,
	input  wire logic signed [18:0] end_coord,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              status,
	output logic [17:0]             start_position,
	output logic [17:0]             end_position,
	output logic [9:0]              start_segment,
	output logic [9:0]              end_segment,
	output logic [18:0]             total_length
);
	localparam int SEG_AW = $clog2(MAX_SEGMENTS > 1 ? MAX_SEGMENTS : 2);
	localparam int N_W = $clog2(MAX_SEGMENTS + 1);
	localparam int WA = $clog2(BIT_WORDS > 1 ? BIT_WORDS : 2);
	localparam longint CAP = longint'(BIT_WORDS) * 64;
	localparam int POS_W = $clog2(CAP + 1);
	localparam int SUM_W = 16 + SEG_AW + 1;
	localparam int QW = (POS_W + 2 > 21) ? POS_W + 2 : 21;

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_SUM  = 4'd2;
	localparam logic [3:0] S_CHK  = 4'd3;
	localparam logic [3:0] S_BRD  = 4'd4;
	localparam logic [3:0] S_BEV  = 4'd5;
	localparam logic [3:0] S_Q1   = 4'd6;
	localparam logic [3:0] S_Q2   = 4'd7;
	localparam logic [3:0] S_Q3   = 4'd8;
	localparam logic [3:0] S_DONE = 4'd9;

	logic [3:0]        state_q;
	logic [10:0]       seg_cnt_q;
	logic              circ_q;
	logic [POS_W-1:0]  len_total_q;
	logic              built_q;
	logic [N_W-1:0]    built_cnt_q;
	logic [N_W-1:0]    i_q;
	logic              pend_q;
	logic [SUM_W-1:0]  sum_q;
	logic [POS_W-1:0]  pos_q;
	logic [WA-1:0]     w_q;
	logic [63:0]       acc_q;
	logic [N_W-1:0]    cum_q;
	logic [N_W-1:0]    base_q;
	logic [2:0]        r_status_q;
	logic [17:0]       r_sp_q;
	logic [17:0]       r_ep_q;
	logic [9:0]        r_ss_q;
	logic [9:0]        r_es_q;

	logic [N_W-1:0]    act;
	logic [N_W-1:0]    n_b;
	logic              emit;

	logic              len_we, len_re;
	logic [SEG_AW-1:0] len_waddr, len_raddr;
	logic [15:0]       len_wdata, len_rdata;
	logic              bv_we, bv_re;
	logic [WA-1:0]     bv_raddr;
	logic [63:0]       bv_rdata;
	logic [N_W-1:0]    rk_rdata;

	logic signed [QW-1:0] a_w, b_w, t_w;
	logic [2:0]         q_status;
	logic               seg_live, same_word;
	logic [63:0]        bit_oh;
	logic [9:0]         loc_idx;
	logic [5:0]         loc_bit;

	always_comb begin
		if (32'(seg_cnt_q) > MAX_SEGMENTS) begin
			act = N_W'(MAX_SEGMENTS);
		end else begin
			act = N_W'(seg_cnt_q);
		end
		n_b = act;
	end

	always_comb begin
		t_w = signed'(QW'(len_total_q));
		a_w = QW'(start_coord);
		b_w = QW'(end_coord);
		if (a_w < 0) begin
			a_w = a_w + t_w;
		end
		if (b_w < 0) begin
			b_w = b_w + t_w;
		end
		if (a_w < 0 || a_w >= t_w) begin
			q_status = ST_START_OUT;
		end else if (b_w < 0 || b_w >= t_w) begin
			q_status = ST_END_OUT;
		end else if (a_w > b_w && !circ_q) begin
			q_status = ST_CROSS;
		end else begin
			q_status = ST_OK;
		end
	end

	assign seg_live  = (i_q < n_b) && (64'(pos_q) < 64'(sum_q));
	assign same_word = 64'(pos_q >> BV_SHIFT) == 64'(w_q);
	assign bit_oh    = 64'd1 << pos_q[5:0];

	assign loc_bit = (state_q == S_Q2) ? r_sp_q[5:0] : r_ep_q[5:0];
	assign loc_idx = 10'(32'(rk_rdata) + 32'(pop64(bv_rdata & ({64{1'b1}} >> (BV_BIT_MASK - loc_bit))))
		- 32'd1);

	assign emit = (state_q == S_DONE) && (!out_valid || out_ready);

	always_comb begin
		len_we    = 1'b0;
		len_waddr = SEG_AW'(i_q);
		len_wdata = '0;
		len_re    = 1'b0;
		len_raddr = SEG_AW'(i_q);
		bv_we     = 1'b0;
		bv_re     = 1'b0;
		bv_raddr  = WA'(r_sp_q >> BV_SHIFT);
		case (state_q)
			S_CLR: begin
				len_we = 1'b1;
			end
			S_IDLE: begin
				if (in_valid && op == OP_LOAD && 32'(segment_index) < 32'(act)) begin
					len_we    = 1'b1;
					len_waddr = SEG_AW'(segment_index);
					len_wdata = segment_length;
				end
			end
			S_SUM: begin
				len_re = i_q < n_b;
			end
			S_BRD: begin
				len_re = i_q < n_b;
			end
			S_BEV: begin
				bv_we = !(seg_live && same_word);
			end
			S_Q1: begin
				bv_re = 1'b1;
			end
			S_Q2: begin
				bv_re    = 1'b1;
				bv_raddr = WA'(r_ep_q >> BV_SHIFT);
			end
			default: begin
			end
		endcase
	end

	bvri_ram #(.WIDTH(16), .DEPTH(MAX_SEGMENTS)) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (len_waddr),
		.wdata (len_wdata),
		.re    (len_re),
		.raddr (len_raddr),
		.rdata (len_rdata)
	);

	bvri_ram #(.WIDTH(64), .DEPTH(BIT_WORDS)) u_bits_ram (
		.clk   (clk),
		.we    (bv_we),
		.waddr (w_q),
		.wdata (acc_q),
		.re    (bv_re),
		.raddr (bv_raddr),
		.rdata (bv_rdata)
	);

	bvri_ram #(.WIDTH(N_W), .DEPTH(BIT_WORDS)) u_rank_ram (
		.clk   (clk),
		.we    (bv_we),
		.waddr (w_q),
		.wdata (base_q),
		.re    (bv_re),
		.raddr (bv_raddr),
		.rdata (rk_rdata)
	);

	assign in_ready = state_q == S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			seg_cnt_q   <= 11'd1;
			circ_q      <= 1'b0;
			len_total_q <= '0;
			built_q     <= 1'b0;
			built_cnt_q <= '0;
			i_q         <= '0;
			pend_q      <= 1'b0;
			out_valid   <= 1'b0;
			r_status_q  <= ST_OK;
			r_sp_q      <= '0;
			r_ep_q      <= '0;
			r_ss_q      <= '0;
			r_es_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SEGMENT_COUNT: seg_cnt_q <= cfg_wdata;
					REG_CIRCULAR_MODE: circ_q <= cfg_wdata[0];
					default: begin
					end
				endcase
			end
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					i_q <= i_q + 1'b1;
					if (32'(i_q) == MAX_SEGMENTS - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						case (op)
							OP_LOAD: begin
								r_status_q <= (32'(segment_index) < 32'(act)) ? ST_OK
									: ST_BAD_INDEX;
								state_q <= S_DONE;
							end
							OP_BUILD: begin
								built_q     <= 1'b0;
								len_total_q <= '0;
								i_q         <= '0;
								pend_q      <= 1'b0;
								sum_q       <= '0;
								state_q     <= S_SUM;
							end
							OP_QUERY: begin
								if (!built_q || len_total_q == '0) begin
									r_status_q <= ST_ZERO_LEN;
									state_q    <= S_DONE;
								end else if (whole_span) begin
									r_status_q <= ST_OK;
									r_ep_q     <= 18'(len_total_q - 1'b1);
									r_es_q     <= 10'(built_cnt_q - 1'b1);
									state_q    <= S_DONE;
								end else if (q_status != ST_OK) begin
									r_status_q <= q_status;
									state_q    <= S_DONE;
								end else begin
									r_status_q <= ST_OK;
									r_sp_q     <= 18'(a_w);
									r_ep_q     <= 18'(b_w);
									state_q    <= S_Q1;
								end
							end
							default: begin
								r_status_q <= ST_BAD_INDEX;
								state_q    <= S_DONE;
							end
						endcase
					end
				end
				S_SUM: begin
					if (pend_q) begin
						sum_q <= sum_q + SUM_W'(len_rdata);
					end
					pend_q <= i_q < n_b;
					if (i_q < n_b) begin
						i_q <= i_q + 1'b1;
					end else if (!pend_q) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (64'(sum_q) > 64'(CAP)) begin
						r_status_q <= ST_OVERFLOW;
						state_q    <= S_DONE;
					end else begin
						i_q     <= '0;
						pos_q   <= '0;
						w_q     <= '0;
						acc_q   <= '0;
						cum_q   <= '0;
						base_q  <= '0;
						state_q <= S_BRD;
					end
				end
				S_BRD: begin
					state_q <= S_BEV;
				end
				S_BEV: begin
					if (seg_live && same_word) begin
						acc_q <= acc_q | bit_oh;
						if ((acc_q & bit_oh) == '0) begin
							cum_q <= cum_q + 1'b1;
						end
						pos_q   <= POS_W'(64'(pos_q) + 64'(len_rdata));
						i_q     <= i_q + 1'b1;
						state_q <= S_BRD;
					end else begin
						acc_q  <= '0;
						base_q <= cum_q;
						w_q    <= w_q + 1'b1;
						if (w_q == WA'(BIT_WORDS - 1)) begin
							len_total_q <= POS_W'(sum_q);
							built_q     <= 1'b1;
							built_cnt_q <= n_b;
							r_status_q  <= ST_OK;
							state_q     <= S_DONE;
						end
					end
				end
				S_Q1: begin
					state_q <= S_Q2;
				end
				S_Q2: begin
					r_ss_q  <= loc_idx;
					state_q <= S_Q3;
				end
				S_Q3: begin
					r_es_q  <= loc_idx;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (emit) begin
						r_sp_q  <= '0;
						r_ep_q  <= '0;
						r_ss_q  <= '0;
						r_es_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status         <= r_status_q;
			start_position <= r_sp_q;
			end_position   <= r_ep_q;
			start_segment  <= r_ss_q;
			end_segment    <= r_es_q;
			total_length   <= 19'(len_total_q);
		end
	end
endmodule
`default_nettype wire
